/* src/pnd_pkg.sv */
package pnd_pkg;

  parameter int unsigned TABLE_SIZE = 256;
  parameter int unsigned FRAC_BITS  = 16;

  typedef enum logic {
    OP_EVAL = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
  } req_t;

  typedef struct packed {
    logic [16:0] noise_value;
    logic        clamped;
  } rsp_t;

endpackage

/* src/perlin_noise_2d_top.sv */
// a result strobes when its evaluate request leaves the end of the valid chain v1_q..v8_q
// throughput: one request per cycle while busy_o is low, set by the 8-stage pipeline with five table copies
// a load request waits (busy_o) while an evaluate request sits in the first two stages
// reset clears pipeline valid bits and the output strobe; table contents are kept
// the receiver cannot stall: every result is shown for exactly one cycle
module perlin_noise_2d_top #(
  parameter int unsigned TableSize = pnd_pkg::TABLE_SIZE,  // power of two
  parameter int unsigned FracBits  = pnd_pkg::FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pnd_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output pnd_pkg::rsp_t rsp_o
);
  import pnd_pkg::*;

  localparam int unsigned IW  = $clog2(TableSize);
  localparam int unsigned F   = FracBits;
  localparam int unsigned GW  = F + 3;         // gradient and lerp values, signed
  localparam int unsigned DW  = GW + 1;        // differences, signed
  localparam int unsigned QW  = F + 6;         // fade polynomial scratch
  localparam int unsigned PW  = F + 2 + DW;    // lerp products
  localparam int unsigned NW  = GW + 1;        // res + one
  localparam int unsigned VW  = NW + 16;       // scaled output scratch
  localparam int unsigned Shr = (F >= 15) ? F - 15 : 0;
  localparam int unsigned Shl = (F < 15) ? 15 - F : 0;
  localparam logic signed [GW-1:0] OneG = GW'(1) <<< F;
  localparam logic signed [VW-1:0] MaxV = VW'(65536);

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic eval_acc, load_acc, acc;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  // a table write must not overtake an evaluate that still has reads pending
  assign busy_o   = start_i && (req_i.opcode == OP_LOAD) && (v1_q || v2_q);
  assign acc      = start_i && !busy_o;
  assign eval_acc = acc && (req_i.opcode == OP_EVAL);
  assign load_acc = acc && (req_i.opcode == OP_LOAD);

  logic [63:0]   x_ext, y_ext;
  logic [IW-1:0] cx, cx1, cy, widx;
  logic [F-1:0]  xf_in, yf_in;

  assign x_ext = 64'($signed(req_i.x_coord));
  assign y_ext = 64'($signed(req_i.y_coord));
  // floor then modulo table size is just the low integer bits
  assign cx    = x_ext[F +: IW];
  assign cy    = y_ext[F +: IW];
  assign cx1   = cx + IW'(1);
  assign xf_in = req_i.x_coord[F-1:0];
  assign yf_in = req_i.y_coord[F-1:0];
  assign widx  = IW'(req_i.table_index);

  // ---------------------------------------------------------------------------
  // valid chain
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else begin
      v1_q <= eval_acc; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
    end
  end

  // ---------------------------------------------------------------------------
  // permutation table: five copies, all written together, each read twice
  // ---------------------------------------------------------------------------
  logic [7:0] mem0 [TableSize];
  logic [7:0] mem1 [TableSize];
  logic [7:0] mem2 [TableSize];
  logic [7:0] mem3 [TableSize];
  logic [7:0] mem4 [TableSize];

  logic [7:0] pa_q, pb_q;            // stage 1: p[cx], p[cx+1]
  logic [7:0] ra_q, ra1_q, rb_q, rb1_q;  // stage 2
  logic [7:0] haa_q, hab_q, hba_q, hbb_q;  // stage 3

  logic [IW-1:0] a_idx, a1_idx, b_idx, b1_idx;
  logic [IW-1:0] cy1_q;

  assign a_idx  = IW'(pa_q) + cy1_q;
  assign a1_idx = a_idx + IW'(1);
  assign b_idx  = IW'(pb_q) + cy1_q;
  assign b1_idx = b_idx + IW'(1);

  always_ff @(posedge clk_i) begin
    if (load_acc) mem0[widx] <= req_i.table_value;
    pa_q <= mem0[cx];
    pb_q <= mem0[cx1];
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) mem1[widx] <= req_i.table_value;
    ra_q  <= mem1[a_idx];
    ra1_q <= mem1[a1_idx];
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) mem2[widx] <= req_i.table_value;
    rb_q  <= mem2[b_idx];
    rb1_q <= mem2[b1_idx];
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) mem3[widx] <= req_i.table_value;
    haa_q <= mem3[IW'(ra_q)];
    hab_q <= mem3[IW'(ra1_q)];
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) mem4[widx] <= req_i.table_value;
    hba_q <= mem4[IW'(rb_q)];
    hbb_q <= mem4[IW'(rb1_q)];
  end

  // ---------------------------------------------------------------------------
  // fade 6t^5 - 15t^4 + 10t^3 over stages 1..3
  // ---------------------------------------------------------------------------
  logic [F-1:0]   xf1_q, yf1_q, xf2_q, yf2_q, xf3_q, yf3_q;
  logic [F-1:0]   t2x_q, t2y_q, t3x_q, t3y_q;
  logic [F+3:0]   qx_q, qy_q;
  logic [F:0]     wu3_q, wv3_q;
  logic [2*F-1:0] sqx, sqy, cbx, cby;
  logic [QW-1:0]  qx_raw, qy_raw;
  logic [2*F+3:0] fx_prod, fy_prod;

  assign sqx = (2*F)'(xf_in) * (2*F)'(xf_in);
  assign sqy = (2*F)'(yf_in) * (2*F)'(yf_in);
  assign cbx = (2*F)'(t2x_q) * (2*F)'(xf1_q);
  assign cby = (2*F)'(t2y_q) * (2*F)'(yf1_q);
  assign qx_raw = QW'(t2x_q) * QW'(6) - QW'(xf1_q) * QW'(15) + (QW'(10) << F);
  assign qy_raw = QW'(t2y_q) * QW'(6) - QW'(yf1_q) * QW'(15) + (QW'(10) << F);
  assign fx_prod = (2*F+4)'(t3x_q) * (2*F+4)'(qx_q);
  assign fy_prod = (2*F+4)'(t3y_q) * (2*F+4)'(qy_q);

  always_ff @(posedge clk_i) begin
    // stage 1
    xf1_q <= xf_in;
    yf1_q <= yf_in;
    cy1_q <= cy;
    t2x_q <= sqx[2*F-1:F];
    t2y_q <= sqy[2*F-1:F];
    // stage 2
    xf2_q <= xf1_q;
    yf2_q <= yf1_q;
    t3x_q <= cbx[2*F-1:F];
    t3y_q <= cby[2*F-1:F];
    qx_q  <= qx_raw[QW-1] ? '0 : qx_raw[F+3:0];
    qy_q  <= qy_raw[QW-1] ? '0 : qy_raw[F+3:0];
    // stage 3
    xf3_q <= xf2_q;
    yf3_q <= yf2_q;
    wu3_q <= fx_prod[F +: F+1];
    wv3_q <= fy_prod[F +: F+1];
  end

  // ---------------------------------------------------------------------------
  // stage 4: corner gradients
  // ---------------------------------------------------------------------------
  function automatic logic signed [GW-1:0] grad(input logic [7:0] hash,
                                                input logic signed [GW-1:0] dx,
                                                input logic signed [GW-1:0] dy);
    logic [3:0] h;
    logic signed [GW-1:0] u, v;
    h = hash[3:0];
    u = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) v = dy;
    else if (h == 4'd12 || h == 4'd14) v = dx;
    else v = '0;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic signed [GW-1:0] dx0, dx1, dy0, dy1;
  logic signed [GW-1:0] gaa_q, gba_q, gab_q, gbb_q;
  logic [F:0]           wu4_q, wv4_q;

  assign dx0 = $signed(GW'(xf3_q));
  assign dy0 = $signed(GW'(yf3_q));
  assign dx1 = dx0 - OneG;
  assign dy1 = dy0 - OneG;

  always_ff @(posedge clk_i) begin
    gaa_q <= grad(haa_q, dx0, dy0);
    gba_q <= grad(hba_q, dx1, dy0);
    gab_q <= grad(hab_q, dx0, dy1);
    gbb_q <= grad(hbb_q, dx1, dy1);
    wu4_q <= wu3_q;
    wv4_q <= wv3_q;
  end

  // ---------------------------------------------------------------------------
  // stages 5..8: bilinear lerp and output scaling
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] d0, d1, d2;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [GW-1:0] gaa5_q, gab5_q, l0_q, l1_q, l07_q;
  logic [F:0]           wv5_q, wv6_q;
  logic signed [GW-1:0] res;
  logic signed [NW-1:0] n;
  logic signed [VW-1:0] nv, val;

  assign d0 = DW'(gba_q) - DW'(gab_q - gab_q + gaa_q);
  assign d1 = DW'(gbb_q) - DW'(gab_q);
  assign d2 = DW'(l1_q) - DW'(l0_q);

  always_ff @(posedge clk_i) begin
    // stage 5
    p0_q   <= PW'($signed({1'b0, wu4_q})) * PW'(d0);
    p1_q   <= PW'($signed({1'b0, wu4_q})) * PW'(d1);
    gaa5_q <= gaa_q;
    gab5_q <= gab_q;
    wv5_q  <= wv4_q;
    // stage 6
    l0_q   <= gaa5_q + GW'(p0_q >>> F);
    l1_q   <= gab5_q + GW'(p1_q >>> F);
    wv6_q  <= wv5_q;
    // stage 7
    p2_q   <= PW'($signed({1'b0, wv6_q})) * PW'(d2);
    l07_q  <= l0_q;
  end

  assign res = l07_q + GW'(p2_q >>> F);
  assign n   = NW'(res) + NW'(OneG);
  assign nv  = VW'(n);
  assign val = (nv <<< Shl) >>> Shr;

  rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d = '0;
    if (val < 0) begin
      rsp_d.noise_value = '0;
      rsp_d.clamped     = 1'b1;
    end else if (val > MaxV) begin
      rsp_d.noise_value = 17'd65536;
      rsp_d.clamped     = 1'b1;
    end else begin
      rsp_d.noise_value = val[16:0];
      rsp_d.clamped     = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = v8_q;
  assign rsp_o       = rsp_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_rsp_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(eval_acc, 8))
    else $error("result without matching evaluate request");

  a_load_no_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |-> !(v1_q || v2_q))
    else $error("table write while evaluate reads pending");

  a_clamp_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.clamped) |->
      (rsp_o.noise_value == 17'd0 || rsp_o.noise_value == 17'd65536))
    else $error("clamped result not at a rail");

endmodule

/* dv/perlin_noise_2d_checker.sv */
`timescale 1ns / 100ps

module perlin_noise_2d_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_o,
  input  pnd_pkg::req_t req_i,
  input  logic          rsp_valid_o,
  input  pnd_pkg::rsp_t rsp_o,
  output int            fail_count_o,
  output int            pending_o
);
  import pnd_pkg::*;

  localparam longint One = longint'(1) << FRAC_BITS;

  logic [7:0] perm_q [TABLE_SIZE];
  rsp_t       noise_q [$];
  int         fail_q = 0;
  int         pend_q = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int unsigned perm_at(longint idx);
    longint m;
    m = idx % TABLE_SIZE;
    if (m < 0) m += TABLE_SIZE;
    return perm_q[m];
  endfunction

  function automatic longint fade(longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    q  = 6 * t2 - 15 * t + 10 * One;
    if (q < 0) q = 0;
    return (t3 * q) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return a + floor_shr(w * (b - a), FRAC_BITS);
  endfunction

  function automatic longint grad(int unsigned hash, longint dx, longint dy);
    int unsigned h;
    longint u, v;
    h = hash & 15;
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
  endfunction

  function automatic rsp_t noise_at(logic signed [31:0] xc, logic signed [31:0] yc);
    longint x, y, xf, yf, cx, cy, wu, wv, a, b, l0, l1, res, val;
    int unsigned haa, hab, hba, hbb;
    rsp_t r;
    x  = longint'(xc);
    y  = longint'(yc);
    xf = x & (One - 1);
    yf = y & (One - 1);
    cx = (x >>> FRAC_BITS) & (TABLE_SIZE - 1);
    cy = (y >>> FRAC_BITS) & (TABLE_SIZE - 1);
    wu = fade(xf);
    wv = fade(yf);
    a  = perm_at(cx) + cy;
    b  = perm_at(cx + 1) + cy;
    haa = perm_at(perm_at(a));
    hab = perm_at(perm_at(a + 1));
    hba = perm_at(perm_at(b));
    hbb = perm_at(perm_at(b + 1));
    l0 = blend(wu, grad(haa, xf, yf), grad(hba, xf - One, yf));
    l1 = blend(wu, grad(hab, xf, yf - One), grad(hbb, xf - One, yf - One));
    res = blend(wv, l0, l1);
    val = floor_shr(res + One, FRAC_BITS - 15);
    r.clamped = 1'b0;
    if (val < 0) begin
      val = 0;
      r.clamped = 1'b1;
    end else if (val > 65536) begin
      val = 65536;
      r.clamped = 1'b1;
    end
    r.noise_value = val[16:0];
    return r;
  endfunction

  assign pending_o    = pend_q;
  assign fail_count_o = fail_q;

  always @(posedge clk_i) begin
    rsp_t exp_r;
    int   errs;
    errs = 0;
    if (rst_ni) begin
      // result first: a request taken this edge cannot produce it
      if (rsp_valid_o) begin
        if (noise_q.size() == 0) begin
          $error("unexpected result noise_value=%0d", rsp_o.noise_value);
          errs++;
        end else begin
          exp_r = noise_q.pop_front();
          if (rsp_o.noise_value !== exp_r.noise_value) begin
            $error("noise_value expected %0d actual %0d", exp_r.noise_value,
                   rsp_o.noise_value);
            errs++;
          end
          if (rsp_o.clamped !== exp_r.clamped) begin
            $error("clamped expected %0d actual %0d", exp_r.clamped, rsp_o.clamped);
            errs++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (req_i.opcode == OP_LOAD)
          perm_q[req_i.table_index % TABLE_SIZE] = req_i.table_value;
        else
          noise_q.push_back(noise_at(req_i.x_coord, req_i.y_coord));
      end
      fail_q <= fail_q + errs;
      pend_q <= noise_q.size();
    end
  end
endmodule

/* dv/perlin_noise_2d_top_test.sv */
`timescale 1ns / 100ps

module perlin_noise_2d_top_test;
  import pnd_pkg::*;

  localparam int Latency  = 8;
  localparam int MaxCycle = 400000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  logic  busy_o;
  req_t  req_i = '0;
  logic  rsp_valid_o;
  rsp_t  rsp_o;
  int    fail_count;
  int    pending;
  int    cycle_count = 0;

  always #5 clk_i = ~clk_i;

  perlin_noise_2d_top u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .rsp_valid_o, .rsp_o
  );

  perlin_noise_2d_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .rsp_valid_o, .rsp_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycle) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // random gap, mostly short, sometimes long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // drive one request and hold it until taken
  task automatic send(req_t r);
    idle_gap();
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic load_entry(int idx, int val);
    req_t r;
    r = '0;
    r.opcode      = OP_LOAD;
    r.table_index = idx[7:0];
    r.table_value = val[7:0];
    r.x_coord     = $urandom;
    r.y_coord     = $urandom;
    send(r);
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y);
    req_t r;
    r.opcode      = OP_EVAL;
    r.x_coord     = x;
    r.y_coord     = y;
    r.table_index = 8'($urandom);
    r.table_value = 8'($urandom);
    send(r);
  endtask

  // point with its fraction pushed toward the cell edges now and then
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 3))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hffff;
      default: ;
    endcase
    return c;
  endfunction

  task automatic fill_table(bit shuffled);
    int perm [256];
    int j, t;
    for (int i = 0; i < 256; i++) perm[i] = i;
    if (shuffled)
      for (int i = 255; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      end
    else
      for (int i = 0; i < 256; i++) perm[i] = $urandom_range(0, 255);
    for (int i = 0; i < 256; i++) load_entry(i, perm[i]);
  endtask

  initial begin
    logic [31:0] edges [6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
              32'h0000_8000, 32'h0001_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry written before any evaluate
    fill_table(1'b1);

    // coordinate extremes and cell edges
    foreach (edges[i])
      foreach (edges[j])
        if (j < 4 || i < 4) eval_point(edges[i], edges[j]);

    // random points, with table rewrites mixed in
    for (int n = 0; n < 1250; n++) begin
      if ($urandom_range(0, 99) < 8)
        load_entry($urandom_range(0, 255), $urandom_range(0, 255));
      else
        eval_point(rand_coord(), rand_coord());
      if (n == 625) fill_table(1'b0);
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/pnd_pkg.sv
src/perlin_noise_2d_top.sv
dv/perlin_noise_2d_checker.sv
dv/perlin_noise_2d_top_test.sv
